// File: sv/fpa_pkg.sv
package fpa_pkg;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_DIV = 4'd3,
      OP_CMP = 4'd4,
      OP_MIN = 4'd5,
      OP_MAX = 4'd6,
      OP_INC = 4'd7,
      OP_DEC = 4'd8
   } opcode_type;

   localparam int RAW_W = 32;

   typedef struct packed {
      logic [3:0]        opcode;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_raw;
      logic               less_than;
      logic               equal_to;
      logic               greater_than;
      logic               overflowed;
      logic               divided_by_zero;
   } rsp_type;

   // classified request handed from front to back
   typedef struct packed {
      logic [3:0]  opcode;
      logic [31:0] raw_a;
      logic [31:0] raw_b;
      logic [31:0] mag_a;
      logic [31:0] mag_b;
      logic        neg;
      logic        lt;
      logic        eq;
      logic        gt;
   } cls_type;

endpackage

// File: sv/fpa_if.sv
interface fpa_req_if import fpa_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface fpa_rsp_if import fpa_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: sv/fpa_front.sv
module fpa_front import fpa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output cls_type out_data
);
   logic    valid_ff, valid_in;
   cls_type data_ff, data_in;
   logic    a_neg, b_neg;

   assign a_neg = in_data.operand_a[31];
   assign b_neg = in_data.operand_b[31];
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in.opcode = in_data.opcode;
      data_in.raw_a  = in_data.operand_a;
      data_in.raw_b  = in_data.operand_b;
      data_in.mag_a  = a_neg ? (~in_data.operand_a + 32'd1) : in_data.operand_a;
      data_in.mag_b  = b_neg ? (~in_data.operand_b + 32'd1) : in_data.operand_b;
      data_in.neg    = a_neg ^ b_neg;
      data_in.lt     = in_data.operand_a < in_data.operand_b;
      data_in.eq     = in_data.operand_a == in_data.operand_b;
      data_in.gt     = in_data.operand_a > in_data.operand_b;
      valid_in       = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

// File: sv/fpa_fifo.sv
module fpa_fifo import fpa_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cls_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output cls_type out_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cls_type        mem [DEPTH];
   logic [AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]    cnt_ff, cnt_in;
   logic           push, pop;

   assign in_ready  = cnt_ff != (AW+1)'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      end
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem[wr_ff] <= in_data;
      end
   end
endmodule

// File: sv/fpa_divider.sv
module fpa_divider import fpa_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        advance,
   input  logic [31:0] mag_a,
   input  logic [31:0] mag_b,
   output logic [63:0] quotient,
   output logic        round_up
);
   // restoring divider, one quotient bit per stage
   localparam int NW = 32 + FRAC_BITS;

   logic [NW-1:0] num_ff [NW+1];
   logic [32:0]   rem_ff [NW+1];
   logic [NW-1:0] quo_ff [NW+1];
   logic [31:0]   den_ff [NW+1];

   always_comb begin
      num_ff[0] = NW'(mag_a) << FRAC_BITS;
      rem_ff[0] = '0;
      quo_ff[0] = '0;
      den_ff[0] = mag_b;
   end

   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic [32:0] shifted, diff;
      logic        take;
      assign shifted = {rem_ff[s][31:0], num_ff[s][NW-1-s]};
      assign diff    = shifted - {1'b0, den_ff[s]};
      assign take    = !diff[32];
      always_ff @(posedge clock) begin
         if (advance) begin
            num_ff[s+1] <= num_ff[s];
            den_ff[s+1] <= den_ff[s];
            rem_ff[s+1] <= take ? diff : shifted;
            quo_ff[s+1] <= {quo_ff[s][NW-2:0], take};
         end
      end
   end

   logic [32:0] twice_r;
   assign twice_r  = {rem_ff[NW][31:0], 1'b0};
   assign round_up = twice_r >= {1'b0, den_ff[NW]};
   assign quotient = 64'(quo_ff[NW]);
endmodule

// File: sv/fpa_back.sv
module fpa_back import fpa_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cls_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);
   localparam int LAT = 32 + FRAC_BITS;

   // one shared pipeline, all ops flow with the divider latency
   logic            advance;
   logic [LAT-1:0]  vld_ff;
   cls_type         cls_ff [LAT];
   logic [63:0]     prod_ff [LAT];
   logic [63:0]     quo_div;
   logic            rnd_div;
   rsp_type         res;
   logic            out_v_ff;
   rsp_type         out_ff;

   assign advance  = !out_v_ff || out_ready;
   assign in_ready = advance;

   fpa_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .advance  (advance),
      .mag_a    (in_data.mag_a),
      .mag_b    (in_data.mag_b),
      .quotient (quo_div),
      .round_up (rnd_div)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         cls_ff[0]  <= in_data;
         prod_ff[0] <= 64'(in_data.mag_a) * 64'(in_data.mag_b);
         for (int i = 1; i < LAT; i++) begin
            cls_ff[i]  <= cls_ff[i-1];
            prod_ff[i] <= prod_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         out_v_ff <= 1'b0;
      end else if (advance) begin
         vld_ff   <= {vld_ff[LAT-2:0], in_valid};
         out_v_ff <= vld_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= res;
      end
   end

   // saturate sign and magnitude
   function automatic logic [32:0] sat_mag(input logic neg, input logic [64:0] mag);
      logic [32:0] r;
      if (neg) begin
         if (mag > 65'h80000000) r = {1'b1, 32'h80000000};
         else r = {1'b0, 32'(~mag[31:0] + 32'd1)};
      end else begin
         if (mag > 65'h7fffffff) r = {1'b1, 32'h7fffffff};
         else r = {1'b0, mag[31:0]};
      end
      return r;
   endfunction

   cls_type     c;
   logic [64:0] mq, dq;
   logic [32:0] sm, sd, sum33;
   logic signed [32:0] wide;
   localparam logic [64:0] HALF = (FRAC_BITS > 0) ? (65'd1 << (FRAC_BITS - 1)) : 65'd0;
   // divider tail, product and class all sit at the last stage
   assign c = cls_ff[LAT-1];

   always_comb begin
      mq = (65'(prod_ff[LAT-1]) + HALF) >> FRAC_BITS;
      dq = 65'(quo_div) + 65'(rnd_div);
      sm = sat_mag(c.neg, mq);
      sd = sat_mag(c.neg, dq);
      wide = '0;
      sum33 = '0;
      res.result_raw      = '0;
      res.overflowed      = 1'b0;
      res.divided_by_zero = 1'b0;
      res.less_than       = c.lt;
      res.equal_to        = c.eq;
      res.greater_than    = c.gt;
      case (c.opcode)
         OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
            case (c.opcode)
               OP_ADD:  wide = $signed({c.raw_a[31], c.raw_a}) + $signed({c.raw_b[31], c.raw_b});
               OP_SUB:  wide = $signed({c.raw_a[31], c.raw_a}) - $signed({c.raw_b[31], c.raw_b});
               OP_INC:  wide = $signed({c.raw_a[31], c.raw_a}) + 33'sd1;
               default: wide = $signed({c.raw_a[31], c.raw_a}) - 33'sd1;
            endcase
            sum33 = wide;
            if (sum33[32] != sum33[31]) begin
               res.overflowed = 1'b1;
               res.result_raw = sum33[32] ? 32'sh80000000 : 32'sh7fffffff;
            end else begin
               res.result_raw = sum33[31:0];
            end
         end
         OP_MUL: begin
            res.result_raw = sm[31:0];
            res.overflowed = sm[32];
         end
         OP_DIV: begin
            if (c.raw_b == '0) begin
               res.divided_by_zero = 1'b1;
            end else begin
               res.result_raw = sd[31:0];
               res.overflowed = sd[32];
            end
         end
         OP_MIN:  res.result_raw = c.lt ? c.raw_a : c.raw_b;
         OP_MAX:  res.result_raw = c.lt ? c.raw_b : c.raw_a;
         default: res.result_raw = '0;
      endcase
   end

   assign out_valid = out_v_ff;
   assign out_data  = out_ff;
endmodule

// File: sv/fixed_point_alu_q24_8.sv
// channel  dir  payload
// req      in   opcode, operand_a, operand_b
// rsp      out  result_raw, less_than, equal_to, greater_than, overflowed, divided_by_zero
//
// one request per cycle while rsp is not stalled; the back pipeline length is set by the
// restoring divider that retires one quotient bit per stage
// synchronous reset empties the front register, queue and back pipeline
// a stalled rsp freezes the back pipeline; the front register and queue
// absorb five more requests before req stalls
module fixed_point_alu_q24_8 import fpa_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input logic clock,
   input logic reset,
   fpa_req_if.sink   req,
   fpa_rsp_if.source rsp
);
   logic    f_valid, f_ready, q_valid, q_ready;
   cls_type f_data, q_data;

   fpa_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
   );

   fpa_fifo #(.DEPTH(4)) u_fifo (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
   );
endmodule

// File: test/fixed_point_alu_q24_8_checker.sv
module fixed_point_alu_q24_8_checker import fpa_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input logic clock,
   input logic reset,
   fpa_req_if req,
   fpa_rsp_if rsp,
   output int fail_count,
   output int pending
);

   localparam longint MAX_POS = 64'sd2147483647;
   localparam longint MIN_NEG = -64'sd2147483648;

   rsp_type expected_q[$];

   function automatic longint saturate(longint v, ref logic ovf);
      if (v > MAX_POS) begin
         ovf = 1'b1;
         return MAX_POS;
      end
      if (v < MIN_NEG) begin
         ovf = 1'b1;
         return MIN_NEG;
      end
      return v;
   endfunction

   function automatic rsp_type alu_result(req_type r);
      rsp_type o;
      longint a, b, res, num, q, rem;
      longint unsigned ma, mb;
      logic ovf, neg;
      a = longint'(r.operand_a);
      b = longint'(r.operand_b);
      ovf = 1'b0;
      res = 0;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      o = '0;
      case (r.opcode)
         OP_ADD: res = saturate(a + b, ovf);
         OP_SUB: res = saturate(a - b, ovf);
         OP_INC: res = saturate(a + 1, ovf);
         OP_DEC: res = saturate(a - 1, ovf);
         OP_MIN: res = (a < b) ? a : b;
         OP_MAX: res = (a < b) ? b : a;
         OP_MUL: begin
            q = longint'(((ma * mb) + ((FRAC_BITS > 0) ? (64'd1 << (FRAC_BITS - 1)) : 0))
                >> FRAC_BITS);
            res = saturate(neg ? -q : q, ovf);
         end
         OP_DIV: begin
            if (b == 0) begin
               o.divided_by_zero = 1'b1;
            end else begin
               num = longint'(ma << FRAC_BITS);
               q = num / longint'(mb);
               rem = num % longint'(mb);
               if (rem >= longint'(mb) - rem) q = q + 1;
               res = saturate(neg ? -q : q, ovf);
            end
         end
         default: res = 0;
      endcase
      o.result_raw = res[31:0];
      o.less_than = a < b;
      o.equal_to = a == b;
      o.greater_than = a > b;
      o.overflowed = ovf;
      return o;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req.valid && req.ready) expected_q.push_back(alu_result(req.data));
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result %h", rsp.data);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_q.pop_front();
               if (exp_r !== rsp.data) begin
                  if (exp_r.result_raw !== rsp.data.result_raw)
                     $error("result_raw exp %h got %h", exp_r.result_raw, rsp.data.result_raw);
                  if (exp_r.less_than !== rsp.data.less_than)
                     $error("less_than exp %b got %b", exp_r.less_than, rsp.data.less_than);
                  if (exp_r.equal_to !== rsp.data.equal_to)
                     $error("equal_to exp %b got %b", exp_r.equal_to, rsp.data.equal_to);
                  if (exp_r.greater_than !== rsp.data.greater_than)
                     $error("greater_than exp %b got %b", exp_r.greater_than,
                            rsp.data.greater_than);
                  if (exp_r.overflowed !== rsp.data.overflowed)
                     $error("overflowed exp %b got %b", exp_r.overflowed, rsp.data.overflowed);
                  if (exp_r.divided_by_zero !== rsp.data.divided_by_zero)
                     $error("divided_by_zero exp %b got %b", exp_r.divided_by_zero,
                            rsp.data.divided_by_zero);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// File: test/fixed_point_alu_q24_8_tb.sv
module fixed_point_alu_q24_8_tb import fpa_pkg::*;;

   localparam int LATENCY = 8 + 34;
   localparam int LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int fail_count, pending, cycles, sent;
   int op_seen[16];

   fpa_req_if req ();
   fpa_rsp_if rsp ();

   fixed_point_alu_q24_8 DUT (.clock(clock), .reset(reset), .req(req), .rsp(rsp));
   fixed_point_alu_q24_8_checker u_checker (.clock(clock), .reset(reset), .req(req),
      .rsp(rsp), .fail_count(fail_count), .pending(pending));

   always #5 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
   end

   // receiver stall pattern: random spells of steady, mostly-ready and mostly-stalled ready
   always @(posedge clock) begin
      int mode_len, mode;
      if (mode_len == 0) begin
         mode_len = $urandom_range(5, 80);
         mode = $urandom_range(0, 2);
      end
      mode_len--;
      rsp.ready <= (mode == 0) ? 1'b1 : (mode == 1) ? ($urandom_range(0, 3) != 0)
                                                   : ($urandom_range(0, 3) == 0);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 3) - 1;
         3: return $urandom_range(0, 4095) - 2048;
         4: return $urandom_range(0, 32'hffff) - 32'h8000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(logic [3:0] op, logic [31:0] a, logic [31:0] b);
      req.valid <= 1'b1;
      req.data <= '{opcode: op, operand_a: a, operand_b: b};
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      op_seen[op]++;
      sent++;
   endtask

   task automatic go_idle(int n);
      req.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   initial begin
      int burst;
      logic [3:0] op;
      logic [31:0] a;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed corners
      send_request(OP_ADD, 32'h7fffffff, 32'h00000001);
      send_request(OP_ADD, 32'h80000000, 32'h80000000);
      send_request(OP_SUB, 32'h80000000, 32'h00000001);
      send_request(OP_SUB, 32'h7fffffff, 32'hffffffff);
      send_request(OP_MUL, 32'h7fffffff, 32'h7fffffff);
      send_request(OP_MUL, 32'h80000000, 32'h80000000);
      send_request(OP_MUL, 32'h80000000, 32'h00000100);
      send_request(OP_MUL, 32'h00000180, 32'hffffff01);
      send_request(OP_DIV, 32'h12345678, 32'h00000000);
      send_request(OP_DIV, 32'h80000000, 32'h00000001);
      send_request(OP_DIV, 32'h80000000, 32'h80000000);
      send_request(OP_DIV, 32'h00000100, 32'hfffffd00);
      send_request(OP_DIV, 32'hffffff00, 32'h00000200);
      send_request(OP_CMP, 32'h00000005, 32'h00000005);
      send_request(OP_CMP, 32'h80000000, 32'h7fffffff);
      send_request(OP_MIN, 32'hffffffff, 32'h00000001);
      send_request(OP_MAX, 32'hffffffff, 32'h00000001);
      send_request(OP_INC, 32'h7fffffff, 32'h00000000);
      send_request(OP_DEC, 32'h80000000, 32'hffffffff);
      send_request(4'd9, 32'h00000003, 32'h00000002);
      send_request(4'd15, 32'hffffffff, 32'hffffffff);
      // pause until all results are back
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      while (sent < 1030) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(0, 8));
            a = pick_operand();
            send_request(op, a, ($urandom_range(0, 5) == 0) ? a : pick_operand());
         end
         if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 12));
      end
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      $display("sent %0d requests over all nine operations and unused codes", sent);
      $display("add %0d mul %0d div %0d cmp %0d", op_seen[0], op_seen[2], op_seen[3],
               op_seen[4]);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
